FILE: rtl/core/xcfr_pkg.sv
// ---------------------------------------------------------------------------
// XOR checked frame receiver package
// Shared types and constants for the frame receiver and its checker.
// ---------------------------------------------------------------------------
package xcfr_pkg;

    // Sync byte that opens every frame (sent twice).
    localparam logic [7:0] SYNC_BYTE = 8'hFF;

    // Result kinds reported for each received word.
    typedef enum logic [2:0] {
        KIND_NONE = 3'd0,
        KIND_DATA = 3'd1,
        KIND_GOOD = 3'd2,
        KIND_BAD  = 3'd3,
        KIND_LEN  = 3'd4
    } kind_t;

    // Receive phases of the framing state machine.
    typedef enum logic [2:0] {
        PH_SYNC1   = 3'd0,
        PH_SYNC2   = 3'd1,
        PH_LEN     = 3'd2,
        PH_PAYLOAD = 3'd3,
        PH_CHECK   = 3'd4
    } phase_t;

    // One result word as it travels from the decoder to the output register.
    typedef struct packed {
        kind_t      kind;
        logic [7:0] data_byte;
        logic [7:0] payload_index;
    } result_t;

endpackage

FILE: rtl/core/xcfr_decoder.sv
// ---------------------------------------------------------------------------
// XOR checked frame receiver: frame decoder
// Holds the framing state and works out the result for one received word.
// ---------------------------------------------------------------------------
module xcfr_decoder (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  logic [7:0]         rx_byte,
    output xcfr_pkg::result_t  result
);

    xcfr_pkg::phase_t phase_reg;
    xcfr_pkg::phase_t phase_next;
    logic [7:0]       remaining_reg;
    logic [7:0]       remaining_next;
    logic [7:0]       xor_reg;
    logic [7:0]       xor_next;
    logic [7:0]       index_reg;
    logic [7:0]       index_next;
    logic [7:0]       remaining_dec;

    assign remaining_dec = remaining_reg - 8'd1;

    // Next state and the result for the word being decoded.
    always_comb
    begin
        phase_next     = phase_reg;
        remaining_next = remaining_reg;
        xor_next       = xor_reg;
        index_next     = index_reg;
        result         = '{kind: xcfr_pkg::KIND_NONE, data_byte: 8'd0, payload_index: 8'd0};

        unique case (phase_reg)
            xcfr_pkg::PH_SYNC2:
            begin
                // A word other than sync sends us back to hunting.
                phase_next = (rx_byte == xcfr_pkg::SYNC_BYTE) ? xcfr_pkg::PH_LEN
                                                               : xcfr_pkg::PH_SYNC1;
            end
            xcfr_pkg::PH_LEN:
            begin
                remaining_next   = rx_byte;
                xor_next         = 8'd0;
                index_next       = 8'd0;
                result.kind      = xcfr_pkg::KIND_LEN;
                result.data_byte = rx_byte;
                // An empty frame goes straight to its checksum.
                phase_next = (rx_byte == 8'd0) ? xcfr_pkg::PH_CHECK : xcfr_pkg::PH_PAYLOAD;
            end
            xcfr_pkg::PH_PAYLOAD:
            begin
                xor_next             = xor_reg ^ rx_byte;
                result.kind          = xcfr_pkg::KIND_DATA;
                result.data_byte     = rx_byte;
                result.payload_index = index_reg;
                index_next           = index_reg + 8'd1;
                remaining_next       = remaining_dec;
                if (remaining_dec == 8'd0)
                begin
                    phase_next = xcfr_pkg::PH_CHECK;
                end
            end
            xcfr_pkg::PH_CHECK:
            begin
                result.kind = (rx_byte == xor_reg) ? xcfr_pkg::KIND_GOOD
                                                   : xcfr_pkg::KIND_BAD;
                phase_next  = xcfr_pkg::PH_SYNC1;
            end
            default:
            begin
                // Hunting the first sync word; unused codes behave the same.
                remaining_next = 8'd0;
                xor_next       = 8'd0;
                index_next     = 8'd0;
                phase_next     = (rx_byte == xcfr_pkg::SYNC_BYTE) ? xcfr_pkg::PH_SYNC2
                                                                  : xcfr_pkg::PH_SYNC1;
            end
        endcase
    end

    // State registers advance once per decoded word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= xcfr_pkg::PH_SYNC1;
            remaining_reg <= 8'd0;
            xor_reg       <= 8'd0;
            index_reg     <= 8'd0;
        end
        else if (step)
        begin
            phase_reg     <= phase_next;
            remaining_reg <= remaining_next;
            xor_reg       <= xor_next;
            index_reg     <= index_next;
        end
    end

endmodule

FILE: rtl/core/xor_checked_frame_receiver.sv
// ---------------------------------------------------------------------------
// XOR checked frame receiver
// Finds sync/length/payload/checksum frames in a byte stream, one result word
// for every received word.
// ---------------------------------------------------------------------------
// Flow: a word accepted into the input register is decoded into the result
// register once that register is empty or being drained. Throughput: one
// word per cycle unless out_stall holds the result register; the framing
// state update is a single level of decode between the two registers.
// Reset: rst_n clears both registers' valid flags and returns the decoder to
// hunting the first sync word.
module xor_checked_frame_receiver (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [2:0] kind,
    output logic [7:0] data_byte,
    output logic [7:0] payload_index
);

    logic               s1_valid_reg;
    logic [7:0]         s1_byte_reg;
    logic               out_valid_reg;
    xcfr_pkg::result_t  result_reg;
    xcfr_pkg::result_t  result_next;
    logic               advance;
    logic               step;

    // The result register can take a word when empty or being drained.
    assign advance  = !out_valid_reg || !out_stall;
    assign step     = s1_valid_reg && advance;
    assign in_stall = s1_valid_reg && !advance;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            s1_byte_reg <= rx_byte;
        end
    end

    xcfr_decoder u_decoder (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .rx_byte (s1_byte_reg),
        .result  (result_next)
    );

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign kind          = result_reg.kind;
    assign data_byte     = result_reg.data_byte;
    assign payload_index = result_reg.payload_index;

endmodule

FILE: rtl/core/xcfr_checker.sv
// ---------------------------------------------------------------------------
// XOR checked frame receiver: port checker
// Watches the top level's ports for protocol and result consistency.
// ---------------------------------------------------------------------------
module xcfr_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic [7:0] rx_byte,
    input logic       out_valid,
    input logic       out_stall,
    input logic [2:0] kind,
    input logic [7:0] data_byte,
    input logic [7:0] payload_index
);

    // A stalled input word stays offered and unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(rx_byte))
    else $error("stalled input word changed");

    // A stalled result word holds its contents.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(kind) && $stable(data_byte)
            && $stable(payload_index))
    else $error("stalled result word changed");

    // Only defined kinds appear.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> kind <= xcfr_pkg::KIND_LEN)
    else $error("undefined result kind");

    // The payload index is zero on everything but payload words.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind != xcfr_pkg::KIND_DATA |-> payload_index == 8'd0)
    else $error("payload index set on a non-payload word");

    // Data is zero on no-result words (sync and hunting) and frame-end words.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == xcfr_pkg::KIND_NONE || kind == xcfr_pkg::KIND_GOOD
            || kind == xcfr_pkg::KIND_BAD) |-> data_byte == 8'd0)
    else $error("data set on a word that carries none");

endmodule

bind xor_checked_frame_receiver xcfr_checker u_xcfr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .rx_byte       (rx_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .kind          (kind),
    .data_byte     (data_byte),
    .payload_index (payload_index)
);

FILE: dv/tb.sv
// ---------------------------------------------------------------------------
// XOR checked frame receiver testbench
// Feeds the frame receiver a short table of hand-picked words and then random
// framed traffic mixed with noise and broken syncs. A behavioural model of
// the framing logic predicts one result word per received word, and every
// output word is compared field by field with the oldest prediction.
// ---------------------------------------------------------------------------
module tb;

    localparam int unsigned ITEM_TARGET = 850;
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned DRAIN_CYCLES = 8;

    // One row of the directed table: the word to send and, where it is obvious,
    // the result it must give.
    typedef struct packed {
        logic [7:0]        rx;
        logic              fixed_want;
        xcfr_pkg::result_t want;
    } stim_row_t;

    localparam int unsigned DIRECTED_ROWS = 24;
    localparam stim_row_t DIRECTED_TABLE [DIRECTED_ROWS] = '{
        // Right after reset a non-sync word gives nothing.
        '{8'h00, 1'b1, '{xcfr_pkg::KIND_NONE, 8'h00, 8'h00}},
        // A lone sync followed by a non-sync word drops back to the hunt.
        '{8'hFF, 1'b0, '0},
        '{8'h7F, 1'b0, '0},
        // Empty frame with the matching zero checksum.
        '{8'hFF, 1'b0, '0},
        '{8'hFF, 1'b0, '0},
        '{8'h00, 1'b1, '{xcfr_pkg::KIND_LEN, 8'h00, 8'h00}},
        '{8'h00, 1'b1, '{xcfr_pkg::KIND_GOOD, 8'h00, 8'h00}},
        // Empty frame with a wrong checksum.
        '{8'hFF, 1'b0, '0},
        '{8'hFF, 1'b0, '0},
        '{8'h00, 1'b1, '{xcfr_pkg::KIND_LEN, 8'h00, 8'h00}},
        '{8'h80, 1'b1, '{xcfr_pkg::KIND_BAD, 8'h00, 8'h00}},
        // Four payload words, extremes included, whose XOR is zero.
        '{8'hFF, 1'b0, '0},
        '{8'hFF, 1'b0, '0},
        '{8'h04, 1'b1, '{xcfr_pkg::KIND_LEN, 8'h04, 8'h00}},
        '{8'hFF, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'h55, 1'b0, '0},
        '{8'hAA, 1'b0, '0},
        '{8'h00, 1'b1, '{xcfr_pkg::KIND_GOOD, 8'h00, 8'h00}},
        // Single payload word with a bad checksum.
        '{8'hFF, 1'b0, '0},
        '{8'hFF, 1'b0, '0},
        '{8'h01, 1'b1, '{xcfr_pkg::KIND_LEN, 8'h01, 8'h00}},
        '{8'h01, 1'b0, '0},
        '{8'h00, 1'b1, '{xcfr_pkg::KIND_BAD, 8'h00, 8'h00}}
    };

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] rx_byte = 8'h00;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [2:0] kind;
    logic [7:0] data_byte;
    logic [7:0] payload_index;

    // Behavioural copy of the framing state.
    xcfr_pkg::phase_t  frame_phase;
    logic [7:0]        bytes_left;
    logic [7:0]        xor_acc;
    logic [7:0]        index_next;

    xcfr_pkg::result_t expected_results [$];

    int unsigned in_idle_pct = 35;
    int unsigned out_stall_pct = 75;
    int unsigned words_sent = 0;
    int unsigned words_checked = 0;
    int unsigned good_frames = 0;
    int unsigned bad_frames = 0;
    int unsigned payload_words = 0;
    int unsigned mismatches = 0;
    int unsigned cycle_count = 0;
    int unsigned hold_left = 0;
    logic        hold_done = 1'b0;

    xor_checked_frame_receiver dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .kind          (kind),
        .data_byte     (data_byte),
        .payload_index (payload_index)
    );

    always #5 clk = ~clk;

    // Advance the framing model by one received word and return its result.
    function automatic xcfr_pkg::result_t frame_decode(input logic [7:0] b);
        xcfr_pkg::result_t res;
        res = '{xcfr_pkg::KIND_NONE, 8'h00, 8'h00};
        case (frame_phase)
            xcfr_pkg::PH_SYNC2:
            begin
                frame_phase = (b == xcfr_pkg::SYNC_BYTE) ? xcfr_pkg::PH_LEN
                                                         : xcfr_pkg::PH_SYNC1;
            end
            xcfr_pkg::PH_LEN:
            begin
                bytes_left = b;
                xor_acc = 8'h00;
                index_next = 8'h00;
                res = '{xcfr_pkg::KIND_LEN, b, 8'h00};
                frame_phase = (b == 8'h00) ? xcfr_pkg::PH_CHECK : xcfr_pkg::PH_PAYLOAD;
            end
            xcfr_pkg::PH_PAYLOAD:
            begin
                xor_acc = xor_acc ^ b;
                res = '{xcfr_pkg::KIND_DATA, b, index_next};
                index_next = index_next + 8'd1;
                bytes_left = bytes_left - 8'd1;
                if (bytes_left == 8'h00)
                begin
                    frame_phase = xcfr_pkg::PH_CHECK;
                end
            end
            xcfr_pkg::PH_CHECK:
            begin
                res.kind = (b == xor_acc) ? xcfr_pkg::KIND_GOOD : xcfr_pkg::KIND_BAD;
                frame_phase = xcfr_pkg::PH_SYNC1;
            end
            default:
            begin
                // Hunting the first sync word; unused phase codes land here too.
                xor_acc = 8'h00;
                index_next = 8'h00;
                bytes_left = 8'h00;
                frame_phase = (b == xcfr_pkg::SYNC_BYTE) ? xcfr_pkg::PH_SYNC2
                                                         : xcfr_pkg::PH_SYNC1;
            end
        endcase
        return res;
    endfunction

    // Offer one word after a random gap, wait for it to be taken and record
    // its expected result. Called just after a falling edge.
    task automatic send_word(input logic [7:0] b, input logic fixed_want = 1'b0,
                             input xcfr_pkg::result_t want = '0);
        xcfr_pkg::result_t pred;
        while ($urandom_range(99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        rx_byte <= b;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        pred = frame_decode(b);
        expected_results.push_back(fixed_want ? want : pred);
        words_sent++;
        @(negedge clk);
    endtask

    // Send a whole frame with random payload and a right or corrupted checksum.
    task automatic send_frame(input int unsigned len, input logic corrupt);
        logic [7:0] chk;
        logic [7:0] pb;
        chk = 8'h00;
        send_word(xcfr_pkg::SYNC_BYTE);
        send_word(xcfr_pkg::SYNC_BYTE);
        send_word(len[7:0]);
        for (int unsigned i = 0; i < len; i++)
        begin
            pb = 8'($urandom_range(0, 255));
            chk = chk ^ pb;
            send_word(pb);
        end
        if (corrupt)
        begin
            chk = chk ^ 8'($urandom_range(1, 255));
        end
        send_word(chk);
    endtask

    // Receiver side: random stalls, plus one long hold-off so that the block
    // fills up and stalls its input while words keep being offered.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (!hold_done && words_sent >= 60)
        begin
            out_stall <= 1'b1;
            hold_left <= HOLD_CYCLES - 1;
            hold_done <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < out_stall_pct);
        end
    end

    // Compare every accepted result word with the oldest prediction.
    always @(posedge clk)
    begin : result_check
        xcfr_pkg::result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result word with nothing expected: kind %0d data %0h index %0d",
                       kind, data_byte, payload_index);
                mismatches++;
            end
            else
            begin
                want = expected_results.pop_front();
                words_checked++;
                if (want.kind == xcfr_pkg::KIND_GOOD) good_frames++;
                if (want.kind == xcfr_pkg::KIND_BAD) bad_frames++;
                if (want.kind == xcfr_pkg::KIND_DATA) payload_words++;
                if (kind !== want.kind)
                begin
                    $error("kind mismatch: expected %0d, actual %0d", want.kind, kind);
                    mismatches++;
                end
                if (data_byte !== want.data_byte)
                begin
                    $error("data_byte mismatch: expected %0h, actual %0h",
                           want.data_byte, data_byte);
                    mismatches++;
                end
                if (payload_index !== want.payload_index)
                begin
                    $error("payload_index mismatch: expected %0d, actual %0d",
                           want.payload_index, payload_index);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles with %0d results outstanding",
                     cycle_count, expected_results.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    // Main sequence: reset, directed table, random traffic, drain.
    initial
    begin
        int unsigned pick;
        int unsigned len;
        logic        long_done;
        long_done = 1'b0;
        frame_phase = xcfr_pkg::PH_SYNC1;
        bytes_left = 8'h00;
        xor_acc = 8'h00;
        index_next = 8'h00;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed words first.
        for (int unsigned r = 0; r < DIRECTED_ROWS; r++)
        begin
            send_word(DIRECTED_TABLE[r].rx, DIRECTED_TABLE[r].fixed_want,
                      DIRECTED_TABLE[r].want);
        end

        // Random traffic: mostly well-formed frames, some noise and broken syncs.
        while (words_sent < ITEM_TARGET)
        begin
            if (words_sent >= 575)
            begin
                in_idle_pct = 0;
                out_stall_pct = 0;
            end
            else if (words_sent >= 300)
            begin
                in_idle_pct = 75;
                out_stall_pct = 35;
            end
            pick = $urandom_range(99);
            if (!long_done && words_sent >= 600)
            begin
                // Longest frame the length field allows, so the payload index reaches 254.
                send_frame(255, 1'b0);
                long_done = 1'b1;
            end
            else if (pick < 10)
            begin
                repeat ($urandom_range(1, 4))
                begin
                    send_word(($urandom_range(3) == 0) ? xcfr_pkg::SYNC_BYTE
                                                       : 8'($urandom_range(0, 255)));
                end
            end
            else if (pick < 16)
            begin
                send_word(xcfr_pkg::SYNC_BYTE);
                send_word(8'($urandom_range(0, 254)));
            end
            else
            begin
                pick = $urandom_range(99);
                if (pick < 20)
                    len = 0;
                else if (pick < 85)
                    len = $urandom_range(1, 8);
                else
                    len = $urandom_range(9, 40);
                send_frame(len, $urandom_range(99) < 25);
            end
        end
        in_valid <= 1'b0;

        // Wait for the pipeline to drain before the summary.
        while (expected_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d words and checked %0d results: %0d good frames, %0d bad,",
                 words_sent, words_checked, good_frames, bad_frames);
        $display("%0d payload words, under sender idling, receiver stalling,",
                 payload_words);
        $display("one long hold-off and a 255 word frame.");
        if (mismatches == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

FILE: xor_checked_frame_receiver.f
rtl/core/xcfr_pkg.sv
rtl/core/xcfr_decoder.sv
rtl/core/xor_checked_frame_receiver.sv
rtl/core/xcfr_checker.sv
dv/tb.sv
